### sv/pbo_pkg.sv
// pbo_pkg: shared types and constants for the polyBLEP oscillator.
// Used by pbo_mul, pbo_div and polyblep_audio_oscillator; no dependencies.
package pbo_pkg;

  localparam int PHASE_BITS_DEF  = 24;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam int QF       = 28;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [63:0] ONEQ  = 64'sd1 <<< QF;
  localparam logic [63:0]        SAT_C = 64'd80530637;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_ON   = 2'd1;
  localparam logic [1:0] FUNC_OFF  = 2'd2;
  localparam logic [1:0] FUNC_RSVD = 2'd3;

  localparam logic [1:0] WAVE_TRI   = 2'd0;
  localparam logic [1:0] WAVE_SAW   = 2'd1;
  localparam logic [1:0] WAVE_PULSE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WAVEFORM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PW       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SAW_G    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TRI_G    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_G  = 3'd7;

  localparam logic [23:0] LEVEL_RST = 24'd4194304;
  localparam logic [15:0] GAIN_RST  = 16'd32768;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [5:0]  sh;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] n;
    logic [63:0] d;
  } div_req_t;

endpackage

### sv/pbo_mul.sv
// pbo_mul: bit-serial sign-magnitude multiplier, product >> sh truncated toward zero.
// One multiplier bit per cycle, stops once the remaining bits are zero. Uses pbo_pkg.
module pbo_mul (
  input  logic              clk,
  input  logic              rst,
  input  pbo_pkg::mul_req_t req,
  output logic              done,
  output logic [63:0]       res
);

  logic [63:0] ma;
  logic [63:0] mb;
  logic [63:0] acc;
  logic [5:0]  sh;
  logic        neg;
  logic        running;
  logic [63:0] mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        ma      <= req.a[63] ? 64'd0 - req.a : req.a;
        mb      <= req.b[63] ? 64'd0 - req.b : req.b;
        neg     <= req.a[63] ^ req.b[63];
        sh      <= req.sh;
        acc     <= '0;
        running <= 1'b1;
      end else if (running) begin
        acc <= acc + (ma[0] ? mb : 64'd0);
        ma  <= ma >> 1;
        mb  <= mb << 1;
        if (ma[63:1] == 63'd0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign mag = acc >> sh;
  assign res = neg ? 64'd0 - mag : mag;

endmodule

### sv/pbo_div.sv
// pbo_div: restoring unsigned 64/64 divider, one quotient bit per cycle.
// Uses pbo_pkg.
module pbo_div (
  input  logic              clk,
  input  logic              rst,
  input  pbo_pkg::div_req_t req,
  output logic              done,
  output logic [63:0]       quo
);

  logic [63:0] rem;
  logic [63:0] den;
  logic [5:0]  cnt;
  logic        running;
  logic [64:0] r2;
  logic [64:0] diff;

  assign r2   = {rem, quo[63]};
  assign diff = r2 - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem     <= '0;
        quo     <= req.n;
        den     <= req.d;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        if (!diff[64]) begin
          rem <= diff[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= r2[63:0];
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

### sv/polyblep_audio_oscillator.sv
// polyblep_audio_oscillator: polyBLEP saw/pulse and triangle oscillator, one item at a time.
// A silent tick goes straight to the output; an active tick runs through the bit-serial
// multiplier and the serial divider, the triangle path taking the fewest of these steps and
// the pulse path with saturation the most. Note on/off give no output. One item in flight.
// Synchronous reset: phase 0, silent, registers to their defaults.
// Uses pbo_pkg, pbo_mul, pbo_div.
module polyblep_audio_oscillator #(
  parameter int PHASE_BITS  = pbo_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = pbo_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          func,
  input  logic [PHASE_BITS-1:0]               phase_inc,
  input  logic signed [SAMPLE_BITS-1:0]       mix_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       sample_out,
  output logic                                sounding,
  input  logic                                cfg_we,
  input  logic [pbo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbo_pkg::CFG_W-1:0]           cfg_data
);

  localparam int PB = PHASE_BITS;
  localparam int SB = SAMPLE_BITS;
  localparam int QL = (PB <= pbo_pkg::QF) ? pbo_pkg::QF - PB : 0;
  localparam int QR = (PB > pbo_pkg::QF) ? PB - pbo_pkg::QF : 0;
  localparam int IW = (PB < 24) ? PB : 24;
  localparam logic [63:0] PH_ONE = 64'd1 << PB;
  localparam logic signed [63:0] LIM_HI = (64'sd1 <<< (SB - 1)) - 64'sd1;
  localparam logic signed [63:0] LIM_LO = -LIM_HI - 64'sd1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SAW   = 4'd1;
  localparam logic [3:0] ST_BDIV  = 4'd2;
  localparam logic [3:0] ST_BMUL  = 4'd3;
  localparam logic [3:0] ST_SAWEND = 4'd4;
  localparam logic [3:0] ST_CDIV  = 4'd5;
  localparam logic [3:0] ST_POST  = 4'd6;
  localparam logic [3:0] ST_SAT1  = 4'd7;
  localparam logic [3:0] ST_SAT2  = 4'd8;
  localparam logic [3:0] ST_SAT3  = 4'd9;
  localparam logic [3:0] ST_MCORR = 4'd10;
  localparam logic [3:0] ST_MLVL  = 4'd11;
  localparam logic [3:0] ST_MGAIN = 4'd12;
  localparam logic [3:0] ST_FIN   = 4'd13;

  // configuration
  logic [1:0]    waveform;
  logic [PB-1:0] duty;
  logic [23:0]   level;
  logic          replace_mode;
  logic          saturation_enable;
  logic [15:0]   saw_gain;
  logic [15:0]   triangle_gain;
  logic [15:0]   pulse_gain;

  // state
  logic [3:0]    state;
  logic [PB-1:0] phase_acc;
  logic          active;

  // working registers
  logic [PB-1:0]       inc;
  logic [PB-1:0]       sp;
  logic signed [63:0]  mix;
  logic signed [63:0]  x;
  logic signed [63:0]  s;
  logic signed [63:0]  corr;
  logic signed [63:0]  res;
  logic [15:0]         gain;
  logic                pass;
  logic                bneg;

  pbo_pkg::mul_req_t mreq;
  pbo_pkg::div_req_t dreq;
  logic              mul_done;
  logic [63:0]       mul_res;
  logic              div_done;
  logic [63:0]       div_q;
  logic              mul_start_next;
  logic              div_start_next;

  pbo_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .done(mul_done), .res(mul_res));
  pbo_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(div_done), .quo(div_q));

  function automatic logic [63:0] to_q(input logic [63:0] v);
    to_q = (v << QL) >> QR;
  endfunction

  // combinational helpers
  logic [63:0]        sp64;
  logic [63:0]        inc64;
  logic [63:0]        ssum;
  logic signed [63:0] tri_d;
  logic [63:0]        tri_m;
  logic [63:0]        pw64;
  logic [63:0]        den;
  logic [PB-1:0]      p2;
  logic signed [63:0] xsat;
  logic [63:0]        fmag;
  logic [63:0]        fcap;
  logic [63:0]        fscl;
  logic signed [63:0] fy;
  logic signed [63:0] fres;

  assign sp64  = 64'(sp);
  assign inc64 = 64'(inc);
  assign ssum  = sp64 + inc64;
  assign tri_d = $signed(64'(phase_acc) << 1) - $signed(PH_ONE);
  assign tri_m = tri_d[63] ? 64'd0 - tri_d : tri_d;
  assign pw64  = 64'(duty);
  assign den   = (pw64 < (PH_ONE >> 1)) ? PH_ONE - pw64 : pw64;
  assign p2    = phase_acc + duty;
  assign xsat  = x - $signed(mul_res);
  assign fmag  = mul_res[63] ? 64'd0 - mul_res : mul_res;
  assign fcap  = (fmag > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : fmag;
  assign fscl  = (fcap << (SB - 1)) >> pbo_pkg::QF;
  assign fy    = mul_res[63] ? $signed(64'd0 - fscl) : $signed(fscl);
  assign fres  = replace_mode ? fy : mix + fy;

  // one-cycle start pulses for the serial units
  assign mul_start_next = (state == ST_POST) || (state == ST_BDIV && div_done) ||
                          (mul_done && (state == ST_SAT1 || state == ST_SAT2 ||
                                        state == ST_SAT3 || state == ST_MCORR ||
                                        state == ST_MLVL));
  assign div_start_next = (state == ST_SAW && (ssum > PH_ONE || sp64 < inc64)) ||
                          (state == ST_SAWEND && waveform != pbo_pkg::WAVE_SAW && pass);

  assign in_ready   = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform          <= pbo_pkg::WAVE_TRI;
      duty              <= PB'(64'd1 << (PB - 1));
      level             <= pbo_pkg::LEVEL_RST;
      replace_mode      <= 1'b0;
      saturation_enable <= 1'b0;
      saw_gain          <= pbo_pkg::GAIN_RST;
      triangle_gain     <= pbo_pkg::GAIN_RST;
      pulse_gain        <= pbo_pkg::GAIN_RST;
      state             <= ST_IDLE;
      phase_acc         <= '0;
      active            <= 1'b0;
      out_valid         <= 1'b0;
      mreq.start        <= 1'b0;
      dreq.start        <= 1'b0;
    end else begin
      mreq.start <= mul_start_next;
      dreq.start <= div_start_next;
      if (out_valid && out_ready && state != ST_FIN) out_valid <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          pbo_pkg::REG_WAVEFORM: waveform          <= cfg_data[1:0];
          pbo_pkg::REG_PW:       duty              <= PB'(cfg_data);
          pbo_pkg::REG_LEVEL:    level             <= cfg_data;
          pbo_pkg::REG_REPLACE:  replace_mode      <= cfg_data[0];
          pbo_pkg::REG_SAT:      saturation_enable <= cfg_data[0];
          pbo_pkg::REG_SAW_G:    saw_gain          <= cfg_data[15:0];
          pbo_pkg::REG_TRI_G:    triangle_gain     <= cfg_data[15:0];
          pbo_pkg::REG_PULSE_G:  pulse_gain        <= cfg_data[15:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            unique case (func)
              pbo_pkg::FUNC_ON: begin
                active    <= 1'b1;
                phase_acc <= (waveform == pbo_pkg::WAVE_TRI) ? PB'(PH_ONE >> 1) : '0;
              end
              pbo_pkg::FUNC_OFF: active <= 1'b0;
              pbo_pkg::FUNC_TICK: begin
                inc  <= PB'(phase_inc[IW-1:0]);
                mix  <= 64'(mix_in);
                corr <= pbo_pkg::ONEQ;
                sp   <= phase_acc;
                pass <= 1'b0;
                if (!active) begin
                  res   <= 64'(mix_in);
                  state <= ST_FIN;
                end else begin
                  case (waveform)
                    pbo_pkg::WAVE_TRI: begin
                      x     <= $signed(to_q(tri_m) << 1) - pbo_pkg::ONEQ;
                      gain  <= triangle_gain;
                      state <= ST_POST;
                    end
                    pbo_pkg::WAVE_SAW: begin
                      x     <= '0;
                      gain  <= saw_gain;
                      state <= ST_SAW;
                    end
                    pbo_pkg::WAVE_PULSE: begin
                      // start from minus the DC term
                      x     <= $signed(to_q(pw64) << 1) - pbo_pkg::ONEQ;
                      gain  <= pulse_gain;
                      state <= ST_SAW;
                    end
                    default: begin
                      x     <= '0;
                      gain  <= '0;
                      state <= ST_POST;
                    end
                  endcase
                end
              end
              default: ;
            endcase
          end
        end
        ST_SAW: begin
          s <= $signed(to_q(sp64 << 1)) - pbo_pkg::ONEQ;
          if (ssum > PH_ONE) begin
            dreq.n     <= (ssum - PH_ONE) << pbo_pkg::QF;
            dreq.d     <= inc64;
            bneg       <= 1'b1;
            state      <= ST_BDIV;
          end else if (sp64 < inc64) begin
            dreq.n     <= (inc64 - sp64) << pbo_pkg::QF;
            dreq.d     <= inc64;
            bneg       <= 1'b0;
            state      <= ST_BDIV;
          end else begin
            state <= ST_SAWEND;
          end
        end
        ST_BDIV: begin
          if (div_done) begin
            mreq.a     <= div_q;
            mreq.b     <= div_q;
            mreq.sh    <= 6'(pbo_pkg::QF);
            state      <= ST_BMUL;
          end
        end
        ST_BMUL: begin
          if (mul_done) begin
            s     <= bneg ? s - $signed(mul_res) : s + $signed(mul_res);
            state <= ST_SAWEND;
          end
        end
        ST_SAWEND: begin
          x <= pass ? x - s : x + s;
          if (waveform == pbo_pkg::WAVE_SAW) begin
            state <= ST_POST;
          end else if (!pass) begin
            sp    <= p2;
            pass  <= 1'b1;
            state <= ST_SAW;
          end else begin
            dreq.n     <= 64'd1 << (2 * pbo_pkg::QF);
            dreq.d     <= to_q(den);
            state      <= ST_CDIV;
          end
        end
        ST_CDIV: begin
          if (div_done) begin
            corr  <= $signed(div_q);
            state <= ST_POST;
          end
        end
        ST_POST: begin
          mreq.sh    <= 6'(pbo_pkg::QF);
          mreq.a     <= x;
          if (saturation_enable) begin
            mreq.b <= x;
            state  <= ST_SAT1;
          end else begin
            mreq.b <= corr;
            state  <= ST_MCORR;
          end
        end
        ST_SAT1: begin
          if (mul_done) begin
            mreq.a     <= mul_res;
            mreq.b     <= x;
            mreq.sh    <= 6'(pbo_pkg::QF);
            state      <= ST_SAT2;
          end
        end
        ST_SAT2: begin
          if (mul_done) begin
            mreq.a     <= pbo_pkg::SAT_C;
            mreq.b     <= mul_res;
            mreq.sh    <= 6'(pbo_pkg::QF);
            state      <= ST_SAT3;
          end
        end
        ST_SAT3: begin
          if (mul_done) begin
            x          <= xsat;
            mreq.a     <= xsat;
            mreq.b     <= corr;
            mreq.sh    <= 6'(pbo_pkg::QF);
            state      <= ST_MCORR;
          end
        end
        ST_MCORR: begin
          if (mul_done) begin
            mreq.a     <= mul_res;
            mreq.b     <= 64'(level);
            mreq.sh    <= 6'd23;
            state      <= ST_MLVL;
          end
        end
        ST_MLVL: begin
          if (mul_done) begin
            mreq.a     <= mul_res;
            mreq.b     <= 64'(gain);
            mreq.sh    <= 6'd15;
            state      <= ST_MGAIN;
          end
        end
        ST_MGAIN: begin
          if (mul_done) begin
            res       <= fres;
            phase_acc <= phase_acc + inc;
            state     <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            sounding  <= active;
            if (res > LIM_HI)      sample_out <= SB'(LIM_HI);
            else if (res < LIM_LO) sample_out <= SB'(LIM_LO);
            else                   sample_out <= SB'(res);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
